// File: design/mmq_pkg.sv
// Shared types and codes for the message match queue.
package mmq_pkg;
  localparam int unsigned OpW = 2;
  localparam int unsigned StW = 2;

  typedef enum logic [OpW-1:0] {
    OP_PUSH  = 2'd0,
    OP_MATCH = 2'd1,
    OP_POP   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_ANY_SRC = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ANY_TAG = 1'b1;

  typedef struct packed {
    logic [3:0]  etype;
    logic [15:0] src;
    logic [15:0] dest;
    logic [31:0] tag;
    logic [31:0] token;
  } entry_t;

  // Match request broadcast to every cell.
  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dest;
    logic [31:0] tag;
    logic [31:0] token;
    logic [15:0] any_src;
    logic [31:0] any_tag;
    logic        take_any;   // pop: every valid entry hits
  } req_t;
endpackage

// File: design/mmq_if.sv
// Valid/ready channel interfaces for the message match queue.
interface mmq_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [3:0]          in_type;
  logic signed [15:0]  in_src;
  logic signed [15:0]  in_dest;
  logic signed [31:0]  in_tag;
  logic [31:0]         in_token;
  modport source (output valid, opcode, in_type, in_src, in_dest, in_tag, in_token,
                  input ready);
  modport sink (input valid, opcode, in_type, in_src, in_dest, in_tag, in_token,
                output ready);
endinterface

interface mmq_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [3:0]          out_type;
  logic signed [15:0]  out_src;
  logic signed [15:0]  out_dest;
  logic signed [31:0]  out_tag;
  logic [31:0]         out_token;
  modport source (output valid, status, out_type, out_src, out_dest, out_tag, out_token,
                  input ready);
  modport sink (input valid, status, out_type, out_src, out_dest, out_tag, out_token,
                output ready);
endinterface

interface mmq_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/mmq_cell.sv
// One queue slot: holds an entry, compares it against the request, shifts.
module mmq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  mmq_pkg::req_t   req,
  input  logic            load,      // write push data into this slot
  input  logic            shift,     // take the neighbor's entry
  input  mmq_pkg::entry_t push_entry,
  input  mmq_pkg::entry_t next_entry,
  input  logic            next_valid,
  output mmq_pkg::entry_t entry,
  output logic            valid,
  output logic            hit_r
);
  mmq_pkg::entry_t entry_r;
  logic            valid_r;
  logic            src_ok;
  logic            tag_ok;
  logic            hit_nxt;

  assign entry = entry_r;
  assign valid = valid_r;

  always_comb begin
    src_ok = (entry_r.src == req.src) || (entry_r.src == req.any_src)
          || (req.src == req.any_src);
    tag_ok = (entry_r.tag == req.tag) || (entry_r.tag == req.any_tag)
          || (req.tag == req.any_tag);
    if (req.take_any) begin
      hit_nxt = valid_r;
    end else if (req.token != 32'd0) begin
      hit_nxt = valid_r && (entry_r.token == req.token);
    end else begin
      hit_nxt = valid_r && (entry_r.dest == req.dest) && src_ok && tag_ok;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= next_valid;
    end else if (load) begin
      valid_r <= 1'b1;
    end
    if (shift) begin
      entry_r <= next_entry;
    end else if (load) begin
      entry_r <= push_entry;
    end
  end
endmodule

// File: design/mmq_pick.sv
// Registered oldest-hit selection: one-hot of the first hit and its entry.
module mmq_pick #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                   clk,
  input  logic [DEPTH-1:0]       hit,
  input  mmq_pkg::entry_t        entries [DEPTH],
  output logic [DEPTH-1:0]       first_r,
  output logic                   any_r,
  output mmq_pkg::entry_t        sel_r
);
  logic [DEPTH-1:0] first;
  mmq_pkg::entry_t  sel;

  // isolate lowest set bit
  assign first = hit & (~hit + DEPTH'(1));

  always_comb begin
    sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel = sel | (first[i] ? entries[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first;
    any_r   <= |hit;
    sel_r   <= sel;
  end
endmodule

// File: design/message_match_queue.sv
// Top level of the message match queue: control, cell row and result register.
// Usage:
//   in  : one operation per beat (push, match-and-remove, pop oldest).
//   out : exactly one result beat per operation: status plus removed entry,
//         zeros when nothing is removed.
//   cfg : writes the any-source (index 0) and any-tag (index 1) wildcard codes;
//         write only while idle.
// Entries sit in a row of QUEUE_DEPTH cells, oldest in cell 0. Every cell
// compares its entry with the broadcast request in parallel, a registered
// priority pick finds the oldest hit, and removal shifts every later cell
// one place toward the head at once.
// A push or unused opcode is answered straight from the compare state; pop and
// match pass through compare, pick and shift, the result written with the shift.
// One item is in flight at a time and the input reopens the cycle after the
// result beat is taken, so no new item is accepted before the last one is answered.
// Reset empties the queue (valid bits clear) and restores wildcard codes -2
// and -1. When the receiver stalls, the result holds in the output register
// and no new item is accepted until it is taken.
module message_match_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic   clk,
  input  logic   rst_n,
  mmq_in_if.sink   in_ch,
  mmq_out_if.source out_ch,
  mmq_cfg_if.sink  cfg_ch
);
  typedef enum logic [2:0] {S_IDLE, S_CMP, S_PICK, S_SHIFT, S_OUT} state_t;

  state_t                 state_r;
  mmq_pkg::req_t          req_r;
  mmq_pkg::entry_t        push_r;
  logic [1:0]             op_r;
  logic [15:0]            any_src_r;
  logic [31:0]            any_tag_r;
  logic                   out_valid_r;
  logic [1:0]             status_r;
  mmq_pkg::entry_t        res_r;

  mmq_pkg::entry_t        entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH-1:0] first_r;
  logic                   any_r;
  mmq_pkg::entry_t        sel_r;
  logic [QUEUE_DEPTH-1:0] shift;
  logic [QUEUE_DEPTH-1:0] load;
  logic [QUEUE_DEPTH-1:0] tail_oh;
  logic                   do_shift;
  logic                   do_load;
  logic                   full;
  logic                   in_fire;

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign full         = valid[QUEUE_DEPTH-1];

  // first free slot
  assign tail_oh  = ~valid & (valid + QUEUE_DEPTH'(1)) ;
  assign do_load  = (state_r == S_CMP) && (op_r == mmq_pkg::OP_PUSH) && !full;
  assign do_shift = (state_r == S_SHIFT) && any_r;
  assign load     = do_load ? tail_oh : '0;

  // shift every cell at or after the removed one
  assign shift = do_shift ? ~(first_r - QUEUE_DEPTH'(1)) : '0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    mmq_pkg::entry_t nxt_e;
    logic            nxt_v;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nxt_e = '0;
      assign nxt_v = 1'b0;
    end else begin : g_mid
      assign nxt_e = entries[g+1];
      assign nxt_v = valid[g+1];
    end
    mmq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .req        (req_r),
      .load       (load[g]),
      .shift      (shift[g]),
      .push_entry (push_r),
      .next_entry (nxt_e),
      .next_valid (nxt_v),
      .entry      (entries[g]),
      .valid      (valid[g]),
      .hit_r      (hit[g])
    );
  end

  mmq_pick #(.DEPTH(QUEUE_DEPTH)) u_pick (
    .clk     (clk),
    .hit     (hit),
    .entries (entries),
    .first_r (first_r),
    .any_r   (any_r),
    .sel_r   (sel_r)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_type  = res_r.etype;
  assign out_ch.out_src   = res_r.src;
  assign out_ch.out_dest  = res_r.dest;
  assign out_ch.out_tag   = res_r.tag;
  assign out_ch.out_token = res_r.token;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r           <= in_ch.opcode;
      push_r         <= {in_ch.in_type, in_ch.in_src, in_ch.in_dest, in_ch.in_tag,
                         in_ch.in_token};
      req_r.src      <= in_ch.in_src;
      req_r.dest     <= in_ch.in_dest;
      req_r.tag      <= in_ch.in_tag;
      req_r.token    <= (in_ch.opcode == mmq_pkg::OP_MATCH) ? in_ch.in_token : 32'd0;
      req_r.any_src  <= any_src_r;
      req_r.any_tag  <= any_tag_r;
      req_r.take_any <= (in_ch.opcode == mmq_pkg::OP_POP);
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      any_src_r   <= 16'hFFFE;
      any_tag_r   <= 32'hFFFF_FFFF;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == mmq_pkg::CFG_ANY_SRC) begin
          any_src_r <= cfg_ch.data[15:0];
        end else begin
          any_tag_r <= cfg_ch.data;
        end
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          res_r <= '0;
          unique case (op_r)
            mmq_pkg::OP_PUSH: begin
              status_r    <= full ? mmq_pkg::ST_FULL : mmq_pkg::ST_OK;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            mmq_pkg::OP_MATCH, mmq_pkg::OP_POP: begin
              state_r <= S_PICK;
            end
            default: begin
              status_r    <= mmq_pkg::ST_MISS;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_PICK: state_r <= S_SHIFT;
        S_SHIFT: begin
          status_r    <= any_r ? mmq_pkg::ST_OK : mmq_pkg::ST_MISS;
          res_r       <= any_r ? sel_r : '0;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
